>>> src/psda_pkg.sv
`default_nettype none

package psda_pkg;

    localparam int MAX_SOURCES  = 5;
    localparam int SUM_WIDTH    = 48;
    localparam int NUM_PAIRS    = MAX_SOURCES * (MAX_SOURCES + 1) / 2;
    localparam int PTR_W        = $clog2(NUM_PAIRS);
    localparam int NUM_COL_REGS = 5;
    localparam int SAMPLE_W     = 16;
    localparam int SQ_W         = 32;
    localparam int DIST_W       = 48;
    localparam int MEMBER_W     = 3;
    localparam int COL_W        = 8;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int MIN_SOURCES  = 3;

    localparam logic [1:0] MODE_VALUE    = 2'd0;
    localparam logic [1:0] MODE_ROW_END  = 2'd1;
    localparam logic [1:0] MODE_END_DATA = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC4   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC5   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd6;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [MAX_SOURCES:0] slots_t;
    typedef logic [NUM_PAIRS-1:0][SQ_W-1:0] squares_t;
    typedef logic [NUM_PAIRS-1:0][SUM_WIDTH-1:0] sums_t;

    typedef struct packed {
        logic [1:0] mode;
        sample_t    sample;
    } in_t;

    typedef struct packed {
        logic [MEMBER_W-1:0] first_member;
        logic [MEMBER_W-1:0] second_member;
        logic [DIST_W-1:0]   distance;
        logic                last;
    } out_t;

    typedef struct packed {
        logic [COL_W-1:0]                     target;
        logic [NUM_COL_REGS-1:0][COL_W-1:0]   source_col;
        logic [COUNT_W-1:0]                   source_count;
    } cfg_t;

    // Marks travelling down the pipeline with each request
    typedef struct packed {
        logic row_end;
        logic end_data;
    } mark_t;

    function automatic logic [COUNT_W-1:0] active_sources(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] n;
        n = count;
        if (n < COUNT_W'(MIN_SOURCES))
            n = COUNT_W'(MIN_SOURCES);
        if (n > COUNT_W'(MAX_SOURCES))
            n = COUNT_W'(MAX_SOURCES);
        return n;
    endfunction

    // Pair p in emission order: target pairs first, then source pairs i<j
    function automatic int pair_first(input int p);
        int k;
        int r;
        k = 0;
        r = 0;
        for (int a = 0; a < MAX_SOURCES; a++)
        begin
            for (int b = a + 1; b <= MAX_SOURCES; b++)
            begin
                if (k == p)
                    r = a;
                k++;
            end
        end
        return r;
    endfunction

    function automatic int pair_second(input int p);
        int k;
        int r;
        k = 0;
        r = 0;
        for (int a = 0; a < MAX_SOURCES; a++)
        begin
            for (int b = a + 1; b <= MAX_SOURCES; b++)
            begin
                if (k == p)
                    r = b;
                k++;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/psda_latch.sv
`default_nettype none

module psda_latch (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            item_valid,
    input  wire psda_pkg::in_t   item,
    input  wire psda_pkg::cfg_t  cfg,
    output psda_pkg::slots_t     slots,
    output psda_pkg::mark_t      mark
);
    import psda_pkg::*;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    slots_t             slots_reg;
    slots_t             slots_next;
    mark_t              mark_reg;
    mark_t              mark_next;
    logic [COL_W-1:0]   col_inc;
    logic               matched;
    logic [COUNT_W-1:0] n;

    assign n       = active_sources(cfg.source_count);
    assign col_inc = col_reg + COL_W'(1);

    always_comb
    begin
        col_next   = col_reg;
        slots_next = slots_reg;
        mark_next  = '0;
        matched    = 1'b0;
        if (item_valid)
        begin
            case (item.mode)
                MODE_VALUE, MODE_ROW_END:
                begin
                    // A saturated counter matches nothing
                    if (col_reg != {COL_W{1'b1}})
                    begin
                        col_next = col_inc;
                        if (col_inc == cfg.target)
                        begin
                            slots_next[0] = item.sample;
                            matched = 1'b1;
                        end
                        for (int s = 0; s < MAX_SOURCES; s++)
                        begin
                            if (!matched && (COUNT_W'(s) < n)
                                && (col_inc == cfg.source_col[s]))
                            begin
                                slots_next[s + 1] = item.sample;
                                matched = 1'b1;
                            end
                        end
                    end
                    if (item.mode == MODE_ROW_END)
                    begin
                        col_next = '0;
                        mark_next.row_end = 1'b1;
                    end
                end
                MODE_END_DATA:
                begin
                    col_next   = '0;
                    slots_next = '0;
                    mark_next.end_data = 1'b1;
                end
                default:
                begin
                    mark_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            slots_reg <= '0;
            mark_reg  <= '0;
        end
        else if (adv)
        begin
            col_reg   <= col_next;
            slots_reg <= slots_next;
            mark_reg  <= mark_next;
        end
    end

    assign slots = slots_reg;
    assign mark  = mark_reg;

endmodule

`default_nettype wire

>>> src/psda_square.sv
`default_nettype none

module psda_square (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire psda_pkg::slots_t  slots,
    input  wire psda_pkg::mark_t   mark_in,
    output psda_pkg::squares_t     squares,
    output psda_pkg::mark_t        mark
);
    import psda_pkg::*;

    squares_t sq_reg;
    squares_t sq_next;
    mark_t    mark_reg;

    genvar p;
    generate
        for (p = 0; p < NUM_PAIRS; p++)
        begin : g_pair
            localparam int A = pair_first(p);
            localparam int B = pair_second(p);
            logic signed [SAMPLE_W:0]       diff;
            logic signed [2*SAMPLE_W+1:0]   prod;

            // Difference of two Q8.8 values is exact in 17 bits
            assign diff = {slots[A][SAMPLE_W-1], slots[A]}
                        - {slots[B][SAMPLE_W-1], slots[B]};
            assign prod = diff * diff;
            assign sq_next[p] = prod[SQ_W-1:0];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv && mark_in.row_end)
            sq_reg <= sq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_reg <= '0;
        else if (adv)
            mark_reg <= mark_in;
    end

    assign squares = sq_reg;
    assign mark    = mark_reg;

endmodule

`default_nettype wire

>>> src/psda_accum.sv
`default_nettype none

module psda_accum (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire psda_pkg::mark_t              mark,
    input  wire psda_pkg::squares_t           squares,
    input  wire logic [psda_pkg::COUNT_W-1:0] n,
    output psda_pkg::sums_t                   sums
);
    import psda_pkg::*;

    sums_t sum_reg;

    genvar p;
    generate
        for (p = 0; p < NUM_PAIRS; p++)
        begin : g_pair
            localparam int B = pair_second(p);
            logic [SUM_WIDTH:0]   total;
            logic [SUM_WIDTH-1:0] sum_next;

            assign total = {1'b0, sum_reg[p]} + (SUM_WIDTH + 1)'(squares[p]);

            always_comb
            begin
                sum_next = sum_reg[p];
                if (mark.end_data)
                    sum_next = '0;
                else if (mark.row_end && (COUNT_W'(B) <= n))
                    sum_next = total[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : total[SUM_WIDTH-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sum_reg[p] <= '0;
                else if (adv)
                    sum_reg[p] <= sum_next;
            end
        end
    endgenerate

    assign sums = sum_reg;

endmodule

`default_nettype wire

>>> src/psda_emit.sv
`default_nettype none

module psda_emit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire psda_pkg::sums_t              sums,
    input  wire logic [psda_pkg::COUNT_W-1:0] n,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output psda_pkg::out_t                    out_data,
    output logic                              load_ok
);
    import psda_pkg::*;

    localparam int EXT_W = (SUM_WIDTH > DIST_W) ? SUM_WIDTH : DIST_W;

    logic [DIST_W-1:0]   buf_reg [NUM_PAIRS];
    logic [MEMBER_W-1:0] first_tab [NUM_PAIRS];
    logic [MEMBER_W-1:0] second_tab [NUM_PAIRS];
    logic [NUM_PAIRS-1:0] active;
    logic                busy_reg;
    logic                busy_next;
    logic [PTR_W-1:0]    ptr_reg;
    logic [PTR_W-1:0]    ptr_next;
    logic [PTR_W-1:0]    ptr_after;
    logic                found;
    logic                take;
    logic                is_last;

    genvar p;
    generate
        for (p = 0; p < NUM_PAIRS; p++)
        begin : g_pair
            logic [EXT_W-1:0] ext;

            assign first_tab[p]  = MEMBER_W'(pair_first(p));
            assign second_tab[p] = MEMBER_W'(pair_second(p));
            assign active[p]     = (MEMBER_W'(pair_second(p)) <= n);
            assign ext           = EXT_W'(sums[p]);

            // Snapshot, clipping wide sums to the distance field
            always_ff @(posedge clk)
            begin
                if (load)
                    buf_reg[p] <= (ext > EXT_W'(DIST_MAX)) ? DIST_MAX : ext[DIST_W-1:0];
            end
        end
    endgenerate

    // Next active pair above the pointer; lowest wins
    always_comb
    begin
        ptr_after = ptr_reg;
        found     = 1'b0;
        for (int q = NUM_PAIRS - 1; q >= 0; q--)
        begin
            if ((PTR_W'(q) > ptr_reg) && active[q])
            begin
                ptr_after = PTR_W'(q);
                found     = 1'b1;
            end
        end
    end

    assign is_last = !found;
    assign take    = busy_reg && !out_stall;
    assign load_ok = !busy_reg || (take && is_last);

    always_comb
    begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        if (take)
        begin
            if (is_last)
                busy_next = 1'b0;
            else
                ptr_next = ptr_after;
        end
        if (load)
        begin
            busy_next = 1'b1;
            ptr_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ptr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
        end
    end

    assign out_valid              = busy_reg;
    assign out_data.first_member  = first_tab[ptr_reg];
    assign out_data.second_member = second_tab[ptr_reg];
    assign out_data.distance      = buf_reg[ptr_reg];
    assign out_data.last          = is_last;

endmodule

`default_nettype wire

>>> src/pairwise_squared_distance_accumulator.sv
// An end-of-data request passes the input, latch and square registers, then loads
// the emitter: one result a cycle (6, 10 or 15 results) while the output is not stalled.
// Throughput: one request a cycle; stall rises only when an end-of-data request
// reaches the output stage while the previous run is still being emitted.
// Reset (asynchronous, active low): configuration to defaults, column counter,
// latched values, sums and pipeline marks cleared; the input item, squares and emission buffer are not.
`default_nettype none

module pairwise_squared_distance_accumulator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_en,
    input  wire logic [psda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [psda_pkg::COL_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire psda_pkg::in_t                  in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output psda_pkg::out_t                      out_data
);
    import psda_pkg::*;

    cfg_t     cfg_reg;
    logic     s1_valid_reg;
    in_t      s1_item_reg;
    slots_t   slots;
    mark_t    s2_mark;
    mark_t    s3_mark;
    squares_t squares;
    sums_t    sums;
    logic     adv;
    logic     load_ok;
    logic [COUNT_W-1:0] n;

    assign n        = active_sources(cfg_reg.source_count);
    // Hold the whole pipeline while an end-of-data request waits for the emitter
    assign adv      = !s3_mark.end_data || load_ok;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target       <= COL_W'(1);
            cfg_reg.source_col   <= {COL_W'(6), COL_W'(5), COL_W'(4), COL_W'(3), COL_W'(2)};
            cfg_reg.source_count <= COUNT_W'(MIN_SOURCES);
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_TARGET: cfg_reg.target        <= cfg_data;
                REG_SRC1:   cfg_reg.source_col[0] <= cfg_data;
                REG_SRC2:   cfg_reg.source_col[1] <= cfg_data;
                REG_SRC3:   cfg_reg.source_col[2] <= cfg_data;
                REG_SRC4:   cfg_reg.source_col[3] <= cfg_data;
                REG_SRC5:   cfg_reg.source_col[4] <= cfg_data;
                REG_COUNT:  cfg_reg.source_count  <= cfg_data[COUNT_W-1:0];
                default:    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            s1_item_reg <= in_data;
    end

    psda_latch u_latch (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (s1_valid_reg),
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .slots      (slots),
        .mark       (s2_mark)
    );

    psda_square u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .slots   (slots),
        .mark_in (s2_mark),
        .squares (squares),
        .mark    (s3_mark)
    );

    psda_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .mark    (s3_mark),
        .squares (squares),
        .n       (n),
        .sums    (sums)
    );

    psda_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && s3_mark.end_data),
        .sums      (sums),
        .n         (n),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .load_ok   (load_ok)
    );

endmodule

`default_nettype wire

>>> src/psda_checker.sv
`default_nettype none

module psda_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           out_valid,
    input  wire logic           out_stall,
    input  wire psda_pkg::out_t out_data
);
    import psda_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Pairs are always ordered
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.first_member < out_data.second_member)
        else $error("pair members out of order");

    // A run does not break before its final result
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> out_valid)
        else $error("run ended without final result");

    // A new run opens with target and source one
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last |=>
            !out_valid || (out_data.first_member == 3'd0 && out_data.second_member == 3'd1))
        else $error("run does not open with first pair");

endmodule

bind pairwise_squared_distance_accumulator psda_checker u_psda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
